// ===== design/assert_macros.svh =====
// Assertion macros shared by checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked property, disabled while the active-low reset is low
`define KVA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same-cycle implication, disabled while the active-low reset is low
`define KVA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`endif

// ===== design/kva_pkg.sv =====
// Types and constants for the keyboard voice allocator.
// No dependencies.
`default_nettype none
package kva_pkg;
  localparam logic [1:0] CMD_KEY = 2'd0;
  localparam logic [1:0] CMD_OCT_UP = 2'd1;
  localparam logic [1:0] CMD_OCT_DOWN = 2'd2;
  localparam logic [3:0] OCTAVE_RESET = 4'd3;
  localparam logic [3:0] OCTAVE_MAX = 4'd8;
  localparam logic [4:0] NO_CHANNEL = 5'd31;
  localparam logic [4:0] NO_OFFSET = 5'd31;
  localparam logic CFG_START_CHANNEL = 1'b0;
  localparam logic CFG_INSTRUMENT = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [8:0] key_code;
    logic       is_down;
    logic       is_repeat;
    logic       modifier_held;
  } in_beat_t;

  typedef struct packed {
    logic       action;
    logic [3:0] channel;
    logic [7:0] note;
    logic [7:0] instrument_out;
    logic       last;
  } out_beat_t;

  // scan token passed along the cell row
  typedef struct packed {
    logic        free_found;
    logic [3:0]  free_ch;
    logic [63:0] min_stamp;
    logic [3:0]  min_ch;
  } scan_t;

  function automatic logic [4:0] semitone(input logic [5:0] u);
    logic [4:0] s;
    unique case (u)
      6'd5: s = 5'd7;   6'd6: s = 5'd4;   6'd7: s = 5'd3;   6'd8: s = 5'd16;
      6'd10: s = 5'd6;  6'd11: s = 5'd8;  6'd12: s = 5'd24;  6'd13: s = 5'd10;
      6'd16: s = 5'd11; 6'd17: s = 5'd9;  6'd20: s = 5'd12;  6'd21: s = 5'd17;
      6'd22: s = 5'd1;  6'd23: s = 5'd19; 6'd24: s = 5'd23;  6'd25: s = 5'd5;
      6'd26: s = 5'd14; 6'd27: s = 5'd2;  6'd28: s = 5'd21;  6'd29: s = 5'd0;
      6'd31: s = 5'd13; 6'd32: s = 5'd15; 6'd34: s = 5'd18;  6'd35: s = 5'd20;
      6'd36: s = 5'd22; 6'd54: s = 5'd12;
      default: s = NO_OFFSET;
    endcase
    return s;
  endfunction
endpackage
`default_nettype wire

// ===== design/kva_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module kva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== design/kva_cell.sv =====
// One voice channel cell: busy flag, use stamp, scan stage.
// Depends on kva_pkg.
`default_nettype none
module kva_cell
  import kva_pkg::*;
#(
  parameter logic [3:0] INDEX = 4'd0
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        scan_en,
  input  wire logic [3:0]  start_ch,
  input  wire scan_t       scan_in,
  output scan_t            scan_out,
  input  wire logic        set_busy,
  input  wire logic        clr_busy,
  input  wire logic        set_stamp,
  input  wire logic [3:0]  sel_ch,
  input  wire logic [63:0] stamp_val
);
  logic        busy_r;
  logic [63:0] stamp_r;
  scan_t       scan_nxt;
  logic        hit;

  assign hit = sel_ch == INDEX;

  always_comb begin
    scan_nxt = scan_in;
    if (!scan_in.free_found && !busy_r && INDEX >= start_ch) begin
      scan_nxt.free_found = 1'b1;
      scan_nxt.free_ch = INDEX;
    end
    if (stamp_r < scan_in.min_stamp) begin
      scan_nxt.min_stamp = stamp_r;
      scan_nxt.min_ch = INDEX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      stamp_r <= '0;
    end else begin
      if (hit && set_busy) busy_r <= 1'b1;
      else if (hit && clr_busy) busy_r <= 1'b0;
      if (hit && set_stamp) stamp_r <= stamp_val;
    end
    if (scan_en) scan_out <= scan_nxt;
  end
endmodule
`default_nettype wire

// ===== design/keyboard_voice_allocator.sv =====
// Top level of the keyboard voice allocator: control sequencer, cell row, key map RAM.
// Depends on kva_pkg, kva_cell, kva_ram.
//
//  channel | handshake          | payload
//  in_     | start / busy       | in_beat_t
//  out_    | out_valid strobe   | out_beat_t
//  cfg_    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A key down passes S_READ, then S_SCAN while the scan token walks each cell of the
// chain and the chain output, then S_ON for the result beat; a steal adds S_OFF
// before S_ON. Key up passes S_READ and S_DONE; octave and ignored events S_READ only.
// After reset a clearing pass writes none to every key map entry, with busy high.
// Results are one-cycle strobes; no stall applies.
`default_nettype none
module keyboard_voice_allocator
  import kva_pkg::*;
#(
  parameter int CHANNELS = 12,
  parameter int KEY_CODES = 512
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_beat_t   in_beat,
  output logic            out_valid,
  output out_beat_t       out_beat,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);
  localparam int KW = $clog2(KEY_CODES);
  localparam int CW = $clog2(CHANNELS + 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_SCAN, S_OFF, S_ON, S_DONE}
    state_t;

  state_t      state_r;
  logic [KW-1:0] clr_r;
  logic [3:0]  start_ch_r;
  logic [7:0]  instr_r;
  logic [3:0]  octave_r;
  logic [63:0] counter_r;
  in_beat_t    item_r;
  logic [4:0]  offset_r;
  logic [CW-1:0] cnt_r;
  logic [3:0]  target_r;

  scan_t chain [CHANNELS+1];
  logic  scan_en;

  logic          ram_we;
  logic [KW-1:0] ram_addr;
  logic [4:0]    ram_wdata, ram_rdata;
  logic          set_busy, clr_busy, set_stamp;
  logic [3:0]    sel_ch;
  logic [7:0]    note_val;

  assign cfg_ready = 1'b1;
  assign busy = state_r != S_IDLE;
  assign scan_en = state_r == S_SCAN;
  assign note_val = 8'(octave_r) * 8'd12 + 8'(offset_r) + 8'd12;

  assign chain[0] = '{free_found: 1'b0, free_ch: 4'd0, min_stamp: '1, min_ch: 4'd0};

  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    kva_cell #(.INDEX(4'(g))) u_cell (
      .clk, .rst_n, .scan_en, .start_ch(start_ch_r),
      .scan_in(chain[g]), .scan_out(chain[g+1]),
      .set_busy, .clr_busy, .set_stamp, .sel_ch, .stamp_val(counter_r + 64'd1)
    );
  end

  kva_ram #(.WIDTH(5), .DEPTH(KEY_CODES)) u_keymap (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_comb begin
    ram_we = 1'b0;
    ram_addr = item_r.key_code[KW-1:0];
    ram_wdata = NO_CHANNEL;
    set_busy = 1'b0;
    clr_busy = 1'b0;
    set_stamp = 1'b0;
    sel_ch = target_r;
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_r;
      end
      S_OFF: clr_busy = 1'b1;
      S_ON: begin
        set_busy = 1'b1;
        set_stamp = 1'b1;
        ram_we = 1'b1;
        ram_wdata = {1'b0, target_r};
      end
      S_DONE: begin
        if (!item_r.is_down) begin
          ram_we = 1'b1;
          sel_ch = ram_rdata[3:0];
          clr_busy = 32'(ram_rdata) < CHANNELS;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      state_r <= S_CLEAR;
      clr_r <= '0;
      start_ch_r <= '0;
      instr_r <= '0;
      octave_r <= OCTAVE_RESET;
      counter_r <= '0;
    end else begin
      out_valid <= (state_r == S_ON) ||
                   (state_r == S_DONE && 32'(ram_rdata) < CHANNELS) ||
                   (state_r == S_SCAN && 32'(cnt_r) == CHANNELS &&
                    !chain[CHANNELS].free_found);
      if (cfg_valid) begin
        if (cfg_index == CFG_START_CHANNEL) start_ch_r <= cfg_data[3:0];
        else if (cfg_index == CFG_INSTRUMENT) instr_r <= cfg_data;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == KEY_CODES - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            item_r <= in_beat;
            offset_r <= (in_beat.key_code[8:6] == 3'd0) ?
                        semitone(in_beat.key_code[5:0]) : NO_OFFSET;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_IDLE;
          cnt_r <= '0;
          if (!item_r.is_repeat) begin
            priority if (item_r.command == CMD_OCT_UP) begin
              if (item_r.is_down && octave_r < OCTAVE_MAX) octave_r <= octave_r + 4'd1;
            end else if (item_r.command == CMD_OCT_DOWN) begin
              if (item_r.is_down && octave_r != 4'd0) octave_r <= octave_r - 4'd1;
            end else if (item_r.command == CMD_KEY && !item_r.modifier_held
                         && offset_r != NO_OFFSET) begin
              state_r <= item_r.is_down ? S_SCAN : S_DONE;
            end
          end
        end
        S_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (32'(cnt_r) == CHANNELS) begin
            if (chain[CHANNELS].free_found) begin
              target_r <= chain[CHANNELS].free_ch;
              state_r <= S_ON;
            end else begin
              target_r <= chain[CHANNELS].min_ch;
              state_r <= S_OFF;
              out_beat <= '{action: 1'b0, channel: chain[CHANNELS].min_ch,
                            note: 8'd0, instrument_out: 8'd0, last: 1'b0};
            end
          end
        end
        S_OFF: state_r <= S_ON;
        S_ON: begin
          counter_r <= counter_r + 64'd1;
          out_beat <= '{action: 1'b1, channel: target_r, note: note_val,
                        instrument_out: instr_r, last: 1'b1};
          state_r <= S_IDLE;
        end
        S_DONE: begin
          if (32'(ram_rdata) < CHANNELS) begin
            out_beat <= '{action: 1'b0, channel: ram_rdata[3:0], note: 8'd0,
                          instrument_out: 8'd0, last: 1'b1};
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/kva_checker.sv =====
// Port-level checker for the keyboard voice allocator, bound to the top level.
// Depends on kva_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module kva_checker
  import kva_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_beat_t out_beat
);
  `KVA_ASSERT(a_take_busy, clk, rst_n, (start && !busy) |=> busy, "accepted beat not busy")
  `KVA_ASSERT_IMP(a_out_busy, clk, rst_n, out_valid, $past(busy), "result while idle")
  `KVA_ASSERT_IMP(a_off_note, clk, rst_n, out_valid && !out_beat.action, out_beat.note == 8'd0,
    "note-off carries note")
  `KVA_ASSERT(a_off_first, clk, rst_n, (out_valid && !out_beat.last) |=> busy && !out_valid,
    "steal note-off not followed by work")
endmodule
bind keyboard_voice_allocator kva_checker u_kva_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_beat
);
`default_nettype wire

// ===== tb/sv/keyboard_voice_allocator_tb.sv =====
// Self-checking testbench for keyboard_voice_allocator: directed table, then random key traffic.
// Results are checked against an in-bench voice allocation model with LRU stealing.
// Depends on kva_pkg and the keyboard_voice_allocator RTL.
`default_nettype none
module keyboard_voice_allocator_tb;
  import kva_pkg::*;

  localparam int NCH = 12;
  localparam int NKEY = 512;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_beat_t in_beat = '0;
  logic out_valid;
  out_beat_t out_beat;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;

  always #5 clk = ~clk;

  keyboard_voice_allocator u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // allocator state mirror
  logic [3:0] m_start_ch;
  logic [7:0] m_instr;
  logic [3:0] m_octave;
  logic m_busy[NCH];
  logic [63:0] m_stamp[NCH];
  logic [63:0] m_counter;
  logic [4:0] m_key_ch[NKEY];

  out_beat_t note_q[$];
  out_beat_t last_beat = '0;
  int errors = 0;
  int mismatches = 0;
  int idle_pct = 35;

  // only a handful of scancodes play notes
  logic [8:0] music_keys[26] = '{29, 22, 27, 7, 6, 25, 10, 5, 11, 17, 13, 16, 54,
                                 20, 31, 26, 32, 8, 21, 34, 23, 35, 28, 36, 24, 12};

  function automatic logic [4:0] key_offset(input logic [8:0] k);
    for (int i = 0; i < 26; i++)
      if (music_keys[i] == k) return (i < 13) ? 5'(i) : 5'(i - 1);
    return NO_OFFSET;
  endfunction

  task automatic alloc_reset();
    m_start_ch = '0;
    m_instr = '0;
    m_octave = OCTAVE_RESET;
    m_counter = '0;
    for (int i = 0; i < NCH; i++) begin
      m_busy[i] = 1'b0;
      m_stamp[i] = '0;
    end
    for (int i = 0; i < NKEY; i++) m_key_ch[i] = NO_CHANNEL;
  endtask

  task automatic predict_voices(input in_beat_t b);
    logic [4:0] off;
    logic [4:0] tgt;
    logic [63:0] oldest;
    out_beat_t r;
    if (b.is_repeat) return;
    if (b.command == CMD_OCT_UP) begin
      if (b.is_down && m_octave < OCTAVE_MAX) m_octave++;
      return;
    end
    if (b.command == CMD_OCT_DOWN) begin
      if (b.is_down && m_octave > 0) m_octave--;
      return;
    end
    if (b.command != CMD_KEY || b.modifier_held) return;
    off = key_offset(b.key_code);
    if (off == NO_OFFSET) return;
    if (b.is_down) begin
      tgt = NO_CHANNEL;
      for (int i = m_start_ch; i < NCH; i++)
        if (!m_busy[i] && tgt == NO_CHANNEL) tgt = 5'(i);
      if (tgt == NO_CHANNEL) begin
        oldest = '1;
        tgt = 5'd0;
        for (int i = 0; i < NCH; i++)
          if (m_stamp[i] < oldest) begin
            oldest = m_stamp[i];
            tgt = 5'(i);
          end
        m_busy[tgt] = 1'b0;
        r = '{action: 1'b0, channel: tgt[3:0], note: 8'd0, instrument_out: 8'd0, last: 1'b0};
        note_q.push_back(r);
      end
      m_key_ch[b.key_code] = tgt;
      m_counter++;
      m_stamp[tgt] = m_counter;
      m_busy[tgt] = 1'b1;
      r = '{action: 1'b1, channel: tgt[3:0], note: 8'(m_octave * 12 + off + 12),
            instrument_out: m_instr, last: 1'b1};
      note_q.push_back(r);
    end else begin
      tgt = m_key_ch[b.key_code];
      if (tgt < NCH) begin
        m_busy[tgt] = 1'b0;
        r = '{action: 1'b0, channel: tgt[3:0], note: 8'd0, instrument_out: 8'd0, last: 1'b1};
        note_q.push_back(r);
      end
      m_key_ch[b.key_code] = NO_CHANNEL;
    end
  endtask

  task automatic flag_mismatch(input out_beat_t exp_b, input out_beat_t act_b);
    errors++;
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: expected %p got %p", exp_b, act_b);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      last_beat = out_beat;
      if (note_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_beat);
      end else begin
        if (out_beat !== note_q[0]) flag_mismatch(note_q[0], out_beat);
        void'(note_q.pop_front());
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_START_CHANNEL) m_start_ch = val[3:0];
    else m_instr = val;
    @(posedge clk);
  endtask

  // start stays high after the accepting edge; the next event or drain sets it
  task automatic send_event(input in_beat_t b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_voices(b);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (note_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic in_beat_t rand_event();
    in_beat_t b;
    int sel;
    b = in_beat_t'($urandom);
    sel = $urandom_range(99);
    if (sel < 80) begin
      b.command = CMD_KEY;
      b.key_code = music_keys[$urandom_range(25)];
      b.is_repeat = ($urandom_range(9) == 0);
      b.modifier_held = ($urandom_range(9) == 0);
    end else if (sel < 90) begin
      b.command = ($urandom_range(1) != 0) ? CMD_OCT_UP : CMD_OCT_DOWN;
    end
    return b;
  endfunction

  typedef struct {
    in_beat_t beat;
    logic typed;
    out_beat_t res;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    in_beat_t b;
    // key Z (offset 0) at octave 3, channel 0: note 48
    rows.push_back('{'{CMD_KEY, 9'd29, 1'b1, 1'b0, 1'b0}, 1'b1, '{1'b1, 4'd0, 8'd48, 8'd0, 1'b1}});
    rows.push_back('{'{CMD_KEY, 9'd29, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 4'd0, 8'd0, 8'd0, 1'b1}});
    rows.push_back('{'{CMD_KEY, 9'd29, 1'b0, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{CMD_KEY, 9'd12, 1'b1, 1'b1, 1'b0}, 1'b0, '0});
    rows.push_back('{'{CMD_KEY, 9'd12, 1'b1, 1'b0, 1'b1}, 1'b0, '0});
    rows.push_back('{'{CMD_KEY, 9'd511, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{CMD_KEY, 9'd63, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{2'd3, 9'd29, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    for (int i = 0; i < 7; i++)
      rows.push_back('{'{CMD_OCT_UP, 9'd0, 1'b1, 1'b0, 1'b1}, 1'b0, '0});
    rows.push_back('{'{CMD_OCT_UP, 9'd0, 1'b0, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{CMD_KEY, 9'd12, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    for (int i = 0; i < 9; i++)
      rows.push_back('{'{CMD_OCT_DOWN, 9'd0, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{CMD_KEY, 9'd29, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{CMD_KEY, 9'd29, 1'b1, 1'b0, 1'b0}, 1'b0, '0});

    alloc_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_event(rows[i].beat);
      if (rows[i].typed) begin
        drain();
        if (note_q.size() != 0 || last_beat !== rows[i].res)
          flag_mismatch(rows[i].res, last_beat);
      end
    end
    drain();

    // steal: start beyond last channel, then instrument extremes
    write_reg(CFG_START_CHANNEL, 8'd15);
    write_reg(CFG_INSTRUMENT, 8'd255);
    for (int i = 0; i < 4; i++) send_event('{CMD_KEY, music_keys[i], 1'b1, 1'b0, 1'b0});
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(CFG_START_CHANNEL, 8'd0); write_reg(CFG_INSTRUMENT, 8'd0); end
        1: begin write_reg(CFG_START_CHANNEL, 8'd11); write_reg(CFG_INSTRUMENT, 8'd170); end
        default: begin
          write_reg(CFG_START_CHANNEL, 8'($urandom_range(15)));
          write_reg(CFG_INSTRUMENT, 8'($urandom));
        end
      endcase
      idle_pct = (phase == 3) ? 0 : 35;
      for (int i = 0; i < 105; i++) begin
        b = rand_event();
        send_event(b);
      end
      drain();
    end

    if (errors == 0) begin
      $display("keyboard_voice_allocator test passed");
    end else begin
      $display("keyboard_voice_allocator test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("keyboard_voice_allocator test failed");
    $finish;
  end
endmodule
`default_nettype wire
